>>> hw/rtl/kdf_pkg.sv
// Shared types, byte codes and the CRC-8 step for the KISS deframer.
// No dependencies; every other file of the block imports this package.
package kdf_pkg;

	localparam logic [7:0] FEND_BYTE  = 8'hC0;
	localparam logic [7:0] FESC_BYTE  = 8'hDB;
	localparam logic [7:0] TFEND_BYTE = 8'hDC;
	localparam logic [7:0] TFESC_BYTE = 8'hDD;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [6:0] LENGTH_MAX = 7'd127;
	localparam logic [1:0] DELIM_MAX  = 2'd3;
	localparam logic [1:0] DELIM_GOOD = 2'd2;

	typedef enum logic {
		ACT_BYTE    = 1'b0,
		ACT_TIMEOUT = 1'b1
	} action_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_OK    = 2'd0,
		VERDICT_SHORT = 2'd1,
		VERDICT_FEND  = 2'd2,
		VERDICT_CRC   = 2'd3
	} verdict_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		verdict_t   verdict;
		logic [6:0] frame_length;
		logic [7:0] command_code;
	} result_t;

	// One byte of CRC-8, MSB first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/kdf_in_stage.sv
// Input register of the deframer: holds one item until the decoder takes it.
// Depends on kdf_pkg for the action type.
module kdf_in_stage
	import kdf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output action_t    action_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action_t'(action);
			byte_s1   <= rx_byte;
		end
	end

`ifndef SYNTHESIS
	// A held item must not be replaced while the decoder has not taken it.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(action_s1))
		else $error("input stage item changed before it was taken");
`endif

endmodule

>>> hw/rtl/kdf_decode.sv
// Frame state and the combinational unescape, CRC and verdict logic.
// Depends on kdf_pkg for byte codes, result type and crc8_update.
module kdf_decode
	import kdf_pkg::*;
#(
	parameter int RAW_BUFFER_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  action_t    action_s1,
	input  logic [7:0] byte_s1,
	output logic       res_has,
	output result_t    res
);

	localparam int CW = $clog2(RAW_BUFFER_BYTES);
	localparam logic [CW-1:0] RAW_LAST = CW'(RAW_BUFFER_BYTES - 1);

	logic [CW-1:0] raw_count_q, raw_count_d;
	logic          start_delim_q, start_delim_d;
	logic [1:0]    delim_count_q, delim_count_d;
	logic          esc_q, esc_d;
	logic [7:0]    crc_q, crc_d;
	logic [6:0]    pay_count_q, pay_count_d;
	logic [7:0]    first_q, first_d;

	logic          emit;
	logic [7:0]    emit_byte;
	logic          plain;
	verdict_t      v;

	always_comb begin
		raw_count_d   = raw_count_q;
		start_delim_d = start_delim_q;
		delim_count_d = delim_count_q;
		esc_d         = esc_q;
		crc_d         = crc_q;
		pay_count_d   = pay_count_q;
		first_d       = first_q;
		emit          = 1'b0;
		emit_byte     = byte_s1;
		plain         = 1'b0;
		res_has       = 1'b0;
		res           = '0;

		if (!start_delim_q || raw_count_q <= CW'(2)) begin
			v = VERDICT_SHORT;
		end else if (delim_count_q != DELIM_GOOD) begin
			v = VERDICT_FEND;
		end else if (crc_q != 8'd0) begin
			v = VERDICT_CRC;
		end else begin
			v = VERDICT_OK;
		end

		if (action_s1 == ACT_TIMEOUT) begin
			res_has          = 1'b1;
			res.kind         = KIND_VERDICT;
			res.verdict      = v;
			res.frame_length = pay_count_q;
			res.command_code = first_q;
			raw_count_d      = '0;
			start_delim_d    = 1'b0;
			delim_count_d    = '0;
			esc_d            = 1'b0;
			crc_d            = '0;
			pay_count_d      = '0;
			first_d          = '0;
		end else if (raw_count_q == RAW_LAST) begin
			// Raw overflow throws away the whole frame so far.
			raw_count_d   = '0;
			start_delim_d = 1'b0;
			delim_count_d = '0;
			esc_d         = 1'b0;
			crc_d         = '0;
			pay_count_d   = '0;
			first_d       = '0;
		end else begin
			if (raw_count_q == '0) begin
				start_delim_d = (byte_s1 == FEND_BYTE);
			end
			raw_count_d = raw_count_q + CW'(1);
			esc_d       = 1'b0;
			plain       = 1'b1;
			if (esc_q) begin
				if (byte_s1 == TFEND_BYTE) begin
					emit      = 1'b1;
					emit_byte = FEND_BYTE;
					plain     = 1'b0;
				end else if (byte_s1 == TFESC_BYTE) begin
					emit      = 1'b1;
					emit_byte = FESC_BYTE;
					plain     = 1'b0;
				end
			end
			if (plain) begin
				if (byte_s1 == FEND_BYTE) begin
					if (delim_count_q != DELIM_MAX) begin
						delim_count_d = delim_count_q + 2'd1;
					end
				end else if (byte_s1 == FESC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			if (emit) begin
				crc_d = crc8_update(crc_q, emit_byte);
				if (pay_count_q == '0) begin
					first_d = emit_byte;
				end
				if (pay_count_q != LENGTH_MAX) begin
					pay_count_d = pay_count_q + 7'd1;
				end
				res_has          = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = emit_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q   <= '0;
			start_delim_q <= 1'b0;
			delim_count_q <= '0;
			esc_q         <= 1'b0;
			crc_q         <= '0;
			pay_count_q   <= '0;
			first_q       <= '0;
		end else if (fire) begin
			raw_count_q   <= raw_count_d;
			start_delim_q <= start_delim_d;
			delim_count_q <= delim_count_d;
			esc_q         <= esc_d;
			crc_q         <= crc_d;
			pay_count_q   <= pay_count_d;
			first_q       <= first_d;
		end
	end

`ifndef SYNTHESIS
	a_raw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		raw_count_q <= RAW_LAST)
		else $error("raw byte count passed the buffer size");
	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> raw_count_q != '0)
		else $error("escape pending outside a frame");
	a_pay_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(pay_count_q != '0 || delim_count_q != '0) |-> raw_count_q != '0)
		else $error("frame counters set with no raw byte");
	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action_s1 == ACT_TIMEOUT |=> raw_count_q == '0 && !esc_q && crc_q == '0)
		else $error("timeout did not clear the frame");
`endif

endmodule

>>> hw/rtl/kdf_out_stage.sv
// Result register of the deframer, driving the output channel.
// Depends on kdf_pkg for the result type.
module kdf_out_stage
	import kdf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       can_load,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [1:0] verdict,
	output logic [6:0] frame_length,
	output logic [7:0] command_code
);

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign verdict      = res_q.verdict;
	assign frame_length = res_q.frame_length;
	assign command_code = res_q.command_code;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(res_q))
		else $error("stalled result was overwritten");
`endif

endmodule

>>> hw/rtl/kiss_deframer_crc8_check.sv
// KISS deframer with CRC-8 frame check, top level.
// Depends on kdf_pkg, kdf_in_stage, kdf_decode and kdf_out_stage.
//
// Input channel (in_valid/in_ready): each item is either a received byte
// (action 0, rx_byte) or a burst timeout (action 1) that closes the frame.
// Output channel (out_valid/out_ready): a result item is a decoded payload
// byte (kind 0) or a frame verdict with length and command code (kind 1).
// FEND and FESC bytes, and bytes dropped on raw overflow, give no result.
// An accepted item waits in the input register while the unescape, CRC-8
// step and verdict logic run on it; its result is then loaded into the
// result register, which drives out_valid. One item per cycle is sustained
// while out_ready is high; the CRC byte update is the longest path.
// When the receiver stalls, the result register holds its item, the input
// register can still take one more item, and in_ready falls only once that
// item needs the result register too. Reset clears the valid flags of both
// registers and the frame state; in_ready is high once reset is released.
module kiss_deframer_crc8_check
	import kdf_pkg::*;
#(
	parameter int RAW_BUFFER_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [1:0] verdict,
	output logic [6:0] frame_length,
	output logic [7:0] command_code
);

	logic       valid_s1;
	action_t    action_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_has;
	result_t    res;
	logic       can_load;

	// An item without a result may leave even while the output is stalled.
	assign advance = valid_s1 && (!res_has || can_load);

	kdf_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.rx_byte   (rx_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.action_s1 (action_s1),
		.byte_s1   (byte_s1)
	);

	kdf_decode #(
		.RAW_BUFFER_BYTES (RAW_BUFFER_BYTES)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.action_s1 (action_s1),
		.byte_s1   (byte_s1),
		.res_has   (res_has),
		.res       (res)
	);

	kdf_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res_has),
		.res          (res),
		.can_load     (can_load),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.verdict      (verdict),
		.frame_length (frame_length),
		.command_code (command_code)
	);

endmodule
